FILE: rtl/core/bmpc_pkg.sv
// ---------------------------------------------------------------------------
// bmpc_pkg
// Shared types and constants of the back-EMF servo controller.
// ---------------------------------------------------------------------------
package bmpc_pkg;

	localparam int NUM_MOTORS    = 4;
	localparam int MOT_W         = 2;
	localparam int PWM_PERIOD    = 240;
	localparam int DEAD_BAND     = 3;
	localparam int ERR_SUM_LIMIT = 170000;
	localparam int FAR_DISTANCE  = 1073741823;
	localparam int PERCENT       = 100;
	localparam int DUTY_MARGIN   = 2;

	localparam int NUM_W = 49;
	localparam int QUO_W = 50;
	localparam int ACC_W = 52;
	localparam int DEN_W = 15;

	localparam int IN_W  = 72;
	localparam int OUT_W = 72;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_MOVE_POS = 3'd1,
		OP_MOVE_VEL = 3'd2,
		OP_POWER    = 3'd3,
		OP_CLEAR    = 3'd4
	} op_e_t;

	typedef enum logic [2:0] {
		CFG_THRESH  = 3'd0,
		CFG_P_MULT  = 3'd1,
		CFG_I_MULT  = 3'd2,
		CFG_D_MULT  = 3'd3,
		CFG_P_DIV   = 3'd4,
		CFG_I_DIV   = 3'd5,
		CFG_D_DIV   = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TERM_P = 2'd0,
		TERM_I = 2'd1,
		TERM_D = 2'd2
	} term_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PLAN,
		ST_ERR,
		ST_MUL,
		ST_DIVGO,
		ST_DIVW,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic  latch;
		logic  exec;
		logic  plan;
		logic  err;
		logic  mul;
		logic  div_start;
		logic  accum;
		logic  sum;
		logic  load_out;
		term_t term;
	} cmd_t;

	typedef struct packed {
		logic run;
		logic is_tick;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/core/bmpc_div.sv
// ---------------------------------------------------------------------------
// bmpc_div
// Shared radix-2 restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, zero divisor gives zero.
// ---------------------------------------------------------------------------
module bmpc_div import bmpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic                    done,
	output logic signed [QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] mag_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;

	logic [DEN_W:0]   trial;
	logic             fits;
	logic [NUM_W-1:0] num_mag;

	assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign trial   = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign fits    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			mag_q <= {mag_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	always_comb begin
		if (den_q == '0)
			quo = '0;
		else if (neg_q)
			quo = -$signed({1'b0, mag_q});
		else
			quo = $signed({1'b0, mag_q});
	end

endmodule

FILE: rtl/core/bmpc_ctrl.sv
// ---------------------------------------------------------------------------
// bmpc_ctrl
// Sequencer: command execution, trajectory step, PID terms, result transfer.
// ---------------------------------------------------------------------------
module bmpc_ctrl import bmpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	term_t  term_q, term_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q  <= TERM_P;
		end else begin
			state_q <= state_d;
			term_q  <= term_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		term_d   = term_q;
		cmd      = '0;
		cmd.term = term_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = (stat.is_tick && stat.run) ? ST_PLAN : ST_OUT;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = ST_ERR;
			end
			ST_ERR: begin
				cmd.err = 1'b1;
				term_d  = TERM_P;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIVGO;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (stat.div_done) begin
					cmd.accum = 1'b1;
					case (term_q)
						TERM_P:  begin term_d = TERM_I; state_d = ST_MUL; end
						TERM_I:  begin term_d = TERM_D; state_d = ST_MUL; end
						default: state_d = ST_SUM;
					endcase
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/core/bmpc_datapath.sv
// ---------------------------------------------------------------------------
// bmpc_datapath
// Per-motor state, gain registers, trajectory and PID arithmetic, result reg.
// ---------------------------------------------------------------------------
module bmpc_datapath import bmpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic [IN_W-1:0]  in_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	// gains
	logic        [15:0] thresh_q;
	logic signed [15:0] p_mult_q, i_mult_q, d_mult_q;
	logic        [14:0] p_div_q, i_div_q, d_div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 16'd100;
			p_mult_q <= 16'sd7;
			i_mult_q <= 16'sd0;
			d_mult_q <= -16'sd2;
			p_div_q  <= 15'd20;
			i_div_q  <= 15'd30;
			d_div_q  <= 15'd1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESH: thresh_q <= cfg_data;
				CFG_P_MULT: p_mult_q <= cfg_data;
				CFG_I_MULT: i_mult_q <= cfg_data;
				CFG_D_MULT: d_mult_q <= cfg_data;
				CFG_P_DIV:  p_div_q  <= cfg_data[14:0];
				CFG_I_DIV:  i_div_q  <= cfg_data[14:0];
				CFG_D_DIV:  d_div_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// latched item
	logic        [2:0]  op_q;
	logic [MOT_W-1:0]   mot_q;
	logic signed [10:0] bemf_q;
	logic signed [15:0] spd_q;
	logic signed [31:0] pos_q;
	logic signed [7:0]  pwr_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= in_data[2:0];
			mot_q  <= in_data[4:3];
			bemf_q <= in_data[15:5];
			spd_q  <= in_data[31:16];
			pos_q  <= in_data[63:32];
			pwr_q  <= in_data[71:64];
		end
	end

	// per-motor state
	logic signed [31:0] pc_q   [NUM_MOTORS];
	logic signed [10:0] sr_q   [NUM_MOTORS];
	logic signed [15:0] ts_q   [NUM_MOTORS];
	logic signed [31:0] tp_q   [NUM_MOTORS];
	logic signed [15:0] pts_q  [NUM_MOTORS];
	logic signed [31:0] ptp_q  [NUM_MOTORS];
	logic signed [31:0] pl_q   [NUM_MOTORS];
	logic signed [31:0] es_q   [NUM_MOTORS];
	logic signed [31:0] pe_q   [NUM_MOTORS];
	logic signed [8:0]  drv_q  [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] moving_q;

	logic signed [31:0] err_q;
	logic signed [NUM_W-1:0] prod_q;
	logic [DEN_W-1:0]   den_q;
	logic signed [ACC_W-1:0] acc_q;

	// exec helpers
	logic               dead;
	logic signed [31:0] pc_new;
	logic               changed;
	logic signed [15:0] spd_mag;
	logic signed [7:0]  pwr_c;
	logic        [6:0]  pwr_a;
	logic        [10:0] pwr_t;
	logic        [23:0] pwr_r;
	logic        [8:0]  pwr_q9;
	logic signed [8:0]  pwr_drv;

	assign dead    = !(bemf_q > 11'sd3 || bemf_q < -11'sd3);
	assign pc_new  = dead ? pc_q[mot_q] : pc_q[mot_q] + 32'(bemf_q);
	assign changed = (pts_q[mot_q] != ts_q[mot_q]) || (ptp_q[mot_q] != tp_q[mot_q]);
	assign spd_mag = (spd_q == -16'sd32768) ? 16'sd32767 :
	                 (spd_q < 0) ? -spd_q : spd_q;
	assign pwr_c   = (pwr_q > 8'sd100) ? 8'sd100 :
	                 (pwr_q < -8'sd100) ? -8'sd100 : pwr_q;
	assign pwr_a   = pwr_c[7] ? 7'(-pwr_c) : 7'(pwr_c);
	assign pwr_t   = 11'(pwr_a) * 11'd12;
	assign pwr_r   = 24'(pwr_t) * 24'd13108;
	assign pwr_q9  = 9'(pwr_r[23:16]);
	assign pwr_drv = pwr_c[7] ? -$signed(pwr_q9) : $signed(pwr_q9);

	// plan helpers
	logic signed [32:0] diff, ts33, th33;
	logic               near_ts, near_th;
	assign diff    = 33'(tp_q[mot_q]) - 33'(pc_q[mot_q]);
	assign ts33    = 33'(ts_q[mot_q]);
	assign th33    = $signed({17'b0, thresh_q});
	assign near_ts = (diff > -ts33) && (diff < ts33);
	assign near_th = (diff > -th33) && (diff < th33);

	// multiplier operands
	logic signed [15:0] mul_a;
	logic signed [32:0] mul_b;
	logic [DEN_W-1:0]   mul_den;
	always_comb begin
		case (cmd.term)
			TERM_P: begin
				mul_a = p_mult_q; mul_b = 33'(err_q); mul_den = p_div_q;
			end
			TERM_I: begin
				mul_a = i_mult_q; mul_b = 33'(es_q[mot_q]); mul_den = i_div_q;
			end
			default: begin
				mul_a   = d_mult_q;
				mul_b   = 33'(pe_q[mot_q]) - 33'(err_q);
				mul_den = d_div_q;
			end
		endcase
	end

	logic                    div_done;
	logic signed [QUO_W-1:0] div_quo;

	bmpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.err)
			acc_q <= '0;
		else if (cmd.accum)
			acc_q <= acc_q + ACC_W'(div_quo);
		if (cmd.err)
			err_q <= pl_q[mot_q] - pc_q[mot_q];
		if (cmd.mul) begin
			prod_q <= NUM_W'(mul_a) * NUM_W'(mul_b);
			den_q  <= mul_den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				pc_q[i]  <= '0; sr_q[i]  <= '0; ts_q[i]  <= '0; tp_q[i] <= '0;
				pts_q[i] <= '0; ptp_q[i] <= '0; pl_q[i]  <= '0; es_q[i] <= '0;
				pe_q[i]  <= '0; drv_q[i] <= '0;
			end
			moving_q <= '0;
		end else begin
			if (cmd.exec) begin
				case (op_e_t'(op_q))
					OP_TICK: begin
						sr_q[mot_q] <= dead ? 11'sd0 : bemf_q;
						pc_q[mot_q] <= pc_new;
						if (ts_q[mot_q] != 0) begin
							if (changed) begin
								es_q[mot_q]     <= '0;
								pl_q[mot_q]     <= pc_new;
								moving_q[mot_q] <= 1'b1;
								pts_q[mot_q]    <= ts_q[mot_q];
								ptp_q[mot_q]    <= tp_q[mot_q];
							end
						end else begin
							moving_q[mot_q] <= 1'b0;
							pts_q[mot_q]    <= '0;
						end
					end
					OP_MOVE_POS: begin
						ts_q[mot_q] <= spd_mag;
						tp_q[mot_q] <= pos_q;
					end
					OP_MOVE_VEL: begin
						ts_q[mot_q] <= spd_mag;
						tp_q[mot_q] <= (spd_q > 0) ? 32'(FAR_DISTANCE) : -32'(FAR_DISTANCE);
					end
					OP_POWER: begin
						ts_q[mot_q]  <= '0;
						drv_q[mot_q] <= pwr_drv;
					end
					OP_CLEAR: begin
						pc_q[mot_q]  <= '0;
						es_q[mot_q]  <= '0;
						pl_q[mot_q]  <= '0;
						ptp_q[mot_q] <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.plan) begin
				if (near_ts) begin
					if (near_th) begin
						pl_q[mot_q]     <= pc_q[mot_q];
						moving_q[mot_q] <= 1'b0;
					end else begin
						pl_q[mot_q] <= pl_q[mot_q] + 32'(diff);
					end
				end else if (diff > 0) begin
					pl_q[mot_q] <= pl_q[mot_q] + 32'(ts_q[mot_q]);
				end else begin
					pl_q[mot_q] <= pl_q[mot_q] - 32'(ts_q[mot_q]);
				end
			end
			if (cmd.err) begin
				if (es_q[mot_q] > 32'sd170000 || es_q[mot_q] < -32'sd170000)
					es_q[mot_q] <= 32'(ERR_SUM_LIMIT);
				else
					es_q[mot_q] <= es_q[mot_q] + (pl_q[mot_q] - pc_q[mot_q]);
			end
			if (cmd.sum) begin
				pe_q[mot_q] <= err_q;
				if (acc_q > ACC_W'(PWM_PERIOD))
					drv_q[mot_q] <= 9'(PWM_PERIOD);
				else if (acc_q < -ACC_W'(PWM_PERIOD))
					drv_q[mot_q] <= -9'(PWM_PERIOD);
				else
					drv_q[mot_q] <= 9'(acc_q);
			end
		end
	end

	// result
	logic signed [8:0] drv;
	logic        [8:0] mag;
	logic        [7:0] duty;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_q;

	assign drv  = drv_q[mot_q];
	assign mag  = drv[8] ? 9'(-drv) : 9'(drv);
	assign duty = (drv == 0) ? 8'(PWM_PERIOD) :
	              (mag > 9'(PWM_PERIOD - DUTY_MARGIN)) ? 8'(DUTY_MARGIN) :
	              8'(9'(PWM_PERIOD) - mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_q <= {4'b0, sr_q[mot_q], pc_q[mot_q], moving_q, drv, duty,
			          (drv > 0), (drv == 0), mot_q};
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.run      = ts_q[mot_q] != 0;
	assign stat.is_tick  = op_e_t'(op_q) == OP_TICK;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

FILE: rtl/core/bemf_motor_pid_position_control.sv
// ---------------------------------------------------------------------------
// bemf_motor_pid_position_control
// Four-motor back-EMF servo controller with profiled PID position control.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one command or tick item per transfer; m_* returns exactly one
//   drive status item per accepted input. cfg_we/cfg_index/cfg_data write the
//   gain and threshold registers; the user must write them only while the
//   block is idle, which the block itself does not enforce. Commands and ticks
//   with no target speed go straight to output; a controlled tick runs the
//   trajectory and error steps, then three PID terms, each a multiply and a 49-step shared division.
//   One item is processed at a time; s_tready is high when the sequencer is
//   idle. The result sits in an output register, so a new item is accepted
//   while m_tvalid waits on m_tready; a second result waits inside until the
//   register frees.
//   Reset clears all motor state, loads the default gains and empties the
//   output register.
// ---------------------------------------------------------------------------
module bemf_motor_pid_position_control import bmpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// op[2:0], motor[4:3], bemf[15:5], speed[31:16], position[63:32], power[71:64]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// motor_out[1:0], motor_off[2], direction[3], duty[11:4], drive[20:12],
	// in_motion[24:21], count[56:25], measured_speed[67:57], zero[71:68]
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	bmpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	a_off_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[11:4] == 8'(PWM_PERIOD) && !m_tdata[3])
		else $error("motor off with wrong duty or direction");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[20:12]) <= 9'sd240 &&
		              $signed(m_tdata[20:12]) >= -9'sd240))
		else $error("drive out of range");

endmodule
